FILE: rtl/pxa_pkg.sv
`default_nettype none

package pxa_pkg;

   // Configuration register indexes (byte address is 4 times the index).
   localparam logic [1:0] REG_GRAY_MODE   = 2'd0;
   localparam logic [1:0] REG_INVERT      = 2'd1;
   localparam logic [1:0] REG_RAMP_SELECT = 2'd2;

   // Gray conversion modes.
   localparam logic [1:0] GRAY_AVERAGE    = 2'd0;
   localparam logic [1:0] GRAY_LIGHTNESS  = 2'd1;
   localparam logic [1:0] GRAY_LUMINOSITY = 2'd2;
   localparam logic [1:0] GRAY_ZERO       = 2'd3;

   // Ramp lengths.
   localparam logic [6:0] SHORT_LEN = 7'd10;
   localparam logic [6:0] LONG_LEN  = 7'd68;

   // Quantizer numerator terms: 2*N*v + 255.
   localparam logic [15:0] SHORT_SCALE = 16'd20;
   localparam logic [15:0] LONG_SCALE  = 16'd136;
   localparam logic [15:0] ROUND_BIAS  = 16'd255;

   // Reciprocals for exact floor division over the value ranges in use.
   // x/3   for x <= 765   : (x * 683)   >> 11
   // x/100 for x <= 25500 : (x * 20972) >> 21
   // x/510 for x <= 34935 : (x * 32897) >> 24
   localparam logic [9:0]  RECIP3   = 10'd683;
   localparam logic [14:0] RECIP100 = 15'd20972;
   localparam logic [15:0] RECIP510 = 16'd32897;

   // Live configuration as seen by the datapath.
   typedef struct packed {
      logic [1:0] gray_mode;
      logic       invert;
      logic       ramp_select;
   } cfg_type;

   // ASCII code of the short ramp " .:-=+*#%@".
   function automatic logic [6:0] glyph_short(input logic [6:0] idx);
      logic [6:0] code;
      case (idx)
         7'd0:    code = 7'h20;
         7'd1:    code = 7'h2E;
         7'd2:    code = 7'h3A;
         7'd3:    code = 7'h2D;
         7'd4:    code = 7'h3D;
         7'd5:    code = 7'h2B;
         7'd6:    code = 7'h2A;
         7'd7:    code = 7'h23;
         7'd8:    code = 7'h25;
         7'd9:    code = 7'h40;
         default: code = 7'h20;
      endcase
      return code;
   endfunction

   // ASCII code of the 68-character ramp, darkest first.
   function automatic logic [6:0] glyph_long(input logic [6:0] idx);
      logic [6:0] code;
      case (idx)
         7'd0:  code = 7'h20;  7'd1:  code = 7'h2E;  7'd2:  code = 7'h27;
         7'd3:  code = 7'h60;  7'd4:  code = 7'h5E;  7'd5:  code = 7'h22;
         7'd6:  code = 7'h2C;  7'd7:  code = 7'h3A;  7'd8:  code = 7'h3B;
         7'd9:  code = 7'h49;  7'd10: code = 7'h6C;  7'd11: code = 7'h21;
         7'd12: code = 7'h69;  7'd13: code = 7'h7E;  7'd14: code = 7'h2B;
         7'd15: code = 7'h5F;  7'd16: code = 7'h2D;  7'd17: code = 7'h3F;
         7'd18: code = 7'h5D;  7'd19: code = 7'h5B;  7'd20: code = 7'h7D;
         7'd21: code = 7'h7B;  7'd22: code = 7'h31;  7'd23: code = 7'h29;
         7'd24: code = 7'h28;  7'd25: code = 7'h7C;  7'd26: code = 7'h5C;
         7'd27: code = 7'h2F;  7'd28: code = 7'h74;  7'd29: code = 7'h66;
         7'd30: code = 7'h6A;  7'd31: code = 7'h72;  7'd32: code = 7'h78;
         7'd33: code = 7'h6E;  7'd34: code = 7'h75;  7'd35: code = 7'h76;
         7'd36: code = 7'h63;  7'd37: code = 7'h7A;  7'd38: code = 7'h58;
         7'd39: code = 7'h59;  7'd40: code = 7'h55;  7'd41: code = 7'h4A;
         7'd42: code = 7'h43;  7'd43: code = 7'h4C;  7'd44: code = 7'h51;
         7'd45: code = 7'h30;  7'd46: code = 7'h4F;  7'd47: code = 7'h5A;
         7'd48: code = 7'h6D;  7'd49: code = 7'h77;  7'd50: code = 7'h71;
         7'd51: code = 7'h70;  7'd52: code = 7'h64;  7'd53: code = 7'h62;
         7'd54: code = 7'h6B;  7'd55: code = 7'h68;  7'd56: code = 7'h61;
         7'd57: code = 7'h6F;  7'd58: code = 7'h2A;  7'd59: code = 7'h23;
         7'd60: code = 7'h4D;  7'd61: code = 7'h57;  7'd62: code = 7'h26;
         7'd63: code = 7'h38;  7'd64: code = 7'h25;  7'd65: code = 7'h42;
         7'd66: code = 7'h40;  7'd67: code = 7'h24;
         default: code = 7'h20;
      endcase
      return code;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/pxa_if.sv
`default_nettype none

// Pixel channel: one RGB pixel per transaction.
interface pxa_pixel_if;
   logic       valid;
   logic       ready;
   logic [7:0] blue;
   logic [7:0] green;
   logic [7:0] red;

   modport source (output valid, output blue, output green, output red, input ready);
   modport sink   (input valid, input blue, input green, input red, output ready);
endinterface

// Glyph channel: one ASCII glyph per transaction.
interface pxa_glyph_if;
   logic       valid;
   logic       ready;
   logic [6:0] glyph;
   logic [6:0] ramp_index;
   logic [7:0] gray_level;

   modport source (output valid, output glyph, output ramp_index, output gray_level,
                   input ready);
   modport sink   (input valid, input glyph, input ramp_index, input gray_level,
                   output ready);
endinterface

`default_nettype wire

FILE: rtl/pxa_csr.sv
`default_nettype none

module pxa_csr
   import pxa_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready,
   output cfg_type          cfg
);

   logic [1:0] gray_mode_ff;
   logic       invert_ff;
   logic       ramp_select_ff;
   logic       write_en;
   logic [1:0] reg_sel;

   assign csr_pready = 1'b1;
   assign write_en   = csr_psel & csr_penable & csr_pwrite;
   assign reg_sel    = csr_paddr[3:2];

   // Register writes; an address past the last register is ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         gray_mode_ff   <= GRAY_AVERAGE;
         invert_ff      <= 1'b0;
         ramp_select_ff <= 1'b0;
      end else if (write_en) begin
         case (reg_sel)
            REG_GRAY_MODE:   gray_mode_ff   <= csr_pwdata[1:0];
            REG_INVERT:      invert_ff      <= csr_pwdata[0];
            REG_RAMP_SELECT: ramp_select_ff <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   // Read mux.
   always_comb begin
      case (reg_sel)
         REG_GRAY_MODE:   csr_prdata = {30'd0, gray_mode_ff};
         REG_INVERT:      csr_prdata = {31'd0, invert_ff};
         REG_RAMP_SELECT: csr_prdata = {31'd0, ramp_select_ff};
         default:         csr_prdata = 32'd0;
      endcase
   end

   assign cfg.gray_mode   = gray_mode_ff;
   assign cfg.invert      = invert_ff;
   assign cfg.ramp_select = ramp_select_ff;

endmodule

`default_nettype wire

FILE: rtl/pxa_gray.sv
`default_nettype none

module pxa_gray
   import pxa_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire cfg_type cfg,
   pxa_pixel_if.sink   req,
   output logic        out_valid,
   input  wire logic   out_ready,
   output logic [7:0]  out_gray
);

   logic        s1_valid_ff;
   logic [9:0]  sum3_ff, sum3_in;
   logic [8:0]  mm_sum_ff, mm_sum_in;
   logic [14:0] lum_sum_ff, lum_sum_in;
   logic        s1_ready;

   logic        s2_valid_ff;
   logic [7:0]  gray_ff, gray_in;
   logic        s2_ready;

   logic [7:0]  hi_bg, lo_bg, chan_max, chan_min;
   logic [19:0] avg_prod;
   logic [29:0] lum_prod;
   logic [7:0]  gray_raw;

   // Each stage takes a new transaction when empty or when its data moves on.
   assign s2_ready  = !s2_valid_ff || out_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign req.ready = s1_ready;

   // Stage 1: channel sum, max plus min, and weighted luminosity sum.
   always_comb begin
      hi_bg      = (req.blue > req.green) ? req.blue : req.green;
      lo_bg      = (req.blue < req.green) ? req.blue : req.green;
      chan_max   = (hi_bg > req.red) ? hi_bg : req.red;
      chan_min   = (lo_bg < req.red) ? lo_bg : req.red;
      sum3_in    = {2'd0, req.blue} + {2'd0, req.green} + {2'd0, req.red};
      mm_sum_in  = {1'b0, chan_max} + {1'b0, chan_min};
      lum_sum_in = ({7'd0, req.blue}  * 15'd7)
                 + ({7'd0, req.green} * 15'd72)
                 + ({7'd0, req.red}   * 15'd21);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_ready) begin
         s1_valid_ff <= req.valid;
      end
      if (s1_ready && req.valid) begin
         sum3_ff    <= sum3_in;
         mm_sum_ff  <= mm_sum_in;
         lum_sum_ff <= lum_sum_in;
      end
   end

   // Stage 2: constant divisions, mode select and optional inversion.
   always_comb begin
      avg_prod = {10'd0, sum3_ff} * {10'd0, RECIP3};
      lum_prod = {15'd0, lum_sum_ff} * {15'd0, RECIP100};
      case (cfg.gray_mode)
         GRAY_AVERAGE:    gray_raw = avg_prod[18:11];
         GRAY_LIGHTNESS:  gray_raw = mm_sum_ff[8:1];
         GRAY_LUMINOSITY: gray_raw = lum_prod[28:21];
         GRAY_ZERO:       gray_raw = 8'd0;
         default:         gray_raw = 8'd0;
      endcase
      gray_in = cfg.invert ? ~gray_raw : gray_raw;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_ready) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (s2_ready && s1_valid_ff) begin
         gray_ff <= gray_in;
      end
   end

   assign out_valid = s2_valid_ff;
   assign out_gray  = gray_ff;

endmodule

`default_nettype wire

FILE: rtl/pxa_quant.sv
`default_nettype none

module pxa_quant
   import pxa_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire cfg_type    cfg,
   input  wire logic       in_valid,
   output logic            in_ready,
   input  wire logic [7:0] in_gray,
   output logic            out_valid,
   input  wire logic       out_ready,
   output logic [6:0]      out_index,
   output logic [7:0]      out_gray
);

   logic        s3_valid_ff;
   logic [15:0] num_ff, num_in;
   logic [7:0]  s3_gray_ff;
   logic        s3_ready;

   logic        s4_valid_ff;
   logic [6:0]  index_ff, index_in;
   logic [7:0]  s4_gray_ff;
   logic        s4_ready;

   logic [31:0] quot_prod;
   logic [6:0]  index_raw;
   logic [6:0]  ramp_len;

   assign s4_ready = !s4_valid_ff || out_ready;
   assign s3_ready = !s3_valid_ff || s4_ready;
   assign in_ready = s3_ready;

   // Stage 3: numerator 2*N*v + 255 for round-half-up of v*N/255.
   assign num_in = ({8'd0, in_gray} * (cfg.ramp_select ? LONG_SCALE : SHORT_SCALE))
                 + ROUND_BIAS;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (s3_ready) begin
         s3_valid_ff <= in_valid;
      end
      if (s3_ready && in_valid) begin
         num_ff     <= num_in;
         s3_gray_ff <= in_gray;
      end
   end

   // Stage 4: divide by 510 through the reciprocal, then clamp to N-1.
   always_comb begin
      quot_prod = {16'd0, num_ff} * {16'd0, RECIP510};
      index_raw = quot_prod[30:24];
      ramp_len  = cfg.ramp_select ? LONG_LEN : SHORT_LEN;
      index_in  = (index_raw >= ramp_len) ? (ramp_len - 7'd1) : index_raw;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (s4_ready) begin
         s4_valid_ff <= s3_valid_ff;
      end
      if (s4_ready && s3_valid_ff) begin
         index_ff   <= index_in;
         s4_gray_ff <= s3_gray_ff;
      end
   end

   assign out_valid = s4_valid_ff;
   assign out_index = index_ff;
   assign out_gray  = s4_gray_ff;

endmodule

`default_nettype wire

FILE: rtl/pxa_glyph.sv
`default_nettype none

module pxa_glyph
   import pxa_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire cfg_type    cfg,
   input  wire logic       in_valid,
   output logic            in_ready,
   input  wire logic [6:0] in_index,
   input  wire logic [7:0] in_gray,
   pxa_glyph_if.source     rsp
);

   logic       out_valid_ff;
   logic [6:0] glyph_ff, glyph_in;
   logic [6:0] index_ff;
   logic [7:0] gray_ff;

   assign in_ready = !out_valid_ff || rsp.ready;

   // Stage 5: ramp lookup into the output register.
   assign glyph_in = cfg.ramp_select ? glyph_long(in_index) : glyph_short(in_index);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (in_ready) begin
         out_valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         glyph_ff <= glyph_in;
         index_ff <= in_index;
         gray_ff  <= in_gray;
      end
   end

   assign rsp.valid      = out_valid_ff;
   assign rsp.glyph      = glyph_ff;
   assign rsp.ramp_index = index_ff;
   assign rsp.gray_level = gray_ff;

endmodule

`default_nettype wire

FILE: rtl/pixel_to_ascii_glyph_top.sv
`default_nettype none

// Channel      Direction  Transaction
// req_pixel    in         one RGB pixel: blue, green, red
// rsp_glyph    out        one result: glyph, ramp_index, gray_level
// csr_*        in/out     APB register write or read
//
// One pixel is accepted every clock while no stall backs up the stages;
// a pixel passes the register stages sums, gray, numerator, index, glyph.
// Reset is synchronous and clears all stage valid bits and the CSRs.
// Each stage holds its data while the next one is full and stalled, so a
// stall on rsp_glyph backs up through the stages without loss or repeat.

module pixel_to_ascii_glyph_top
   import pxa_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   pxa_pixel_if.sink        req_pixel,
   pxa_glyph_if.source      rsp_glyph,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   cfg_type    cfg;
   logic       gray_valid, gray_ready;
   logic [7:0] gray_value;
   logic       quant_valid, quant_ready;
   logic [6:0] quant_index;
   logic [7:0] quant_gray;

   // Configuration registers.
   pxa_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Gray conversion, stages 1 and 2.
   pxa_gray u_gray (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req       (req_pixel),
      .out_valid (gray_valid),
      .out_ready (gray_ready),
      .out_gray  (gray_value)
   );

   // Ramp quantizer, stages 3 and 4.
   pxa_quant u_quant (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (gray_valid),
      .in_ready  (gray_ready),
      .in_gray   (gray_value),
      .out_valid (quant_valid),
      .out_ready (quant_ready),
      .out_index (quant_index),
      .out_gray  (quant_gray)
   );

   // Glyph lookup and output register, stage 5.
   pxa_glyph u_glyph (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .in_valid (quant_valid),
      .in_ready (quant_ready),
      .in_index (quant_index),
      .in_gray  (quant_gray),
      .rsp      (rsp_glyph)
   );

endmodule

`default_nettype wire

FILE: tb/sv/pixel_to_ascii_glyph_top_tb.sv
module pixel_to_ascii_glyph_top_tb
   import pxa_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   // One glyph transaction as the receiver sees it.
   typedef struct packed {
      logic [6:0] glyph;
      logic [6:0] ramp_index;
      logic [7:0] gray_level;
   } glyph_result_type;

   // One row of the directed stimulus: the settings, the pixel and, where it is
   // obvious, the glyph that must come back.
   typedef struct packed {
      logic [1:0]       gray_mode;
      logic             invert;
      logic             ramp_select;
      logic [7:0]       blue;
      logic [7:0]       green;
      logic [7:0]       red;
      logic             typed;
      glyph_result_type want;
   } pixel_case_type;

   localparam glyph_result_type UNTYPED = '0;
   localparam logic [3:0] UNMAPPED_ADDR = 4'hC;
   localparam int PIPE_DRAIN_CYCLES = 8;
   localparam int STALL_LIMIT = 5000;
   localparam int SEGMENTS = 32;
   localparam int PIXELS_PER_SEGMENT = 19;
   localparam int DIRECTED_ROWS = 20;

   // Directed rows are grouped by settings so that few register updates are needed.
   pixel_case_type directed_cases [0:DIRECTED_ROWS-1] = '{
      '{GRAY_AVERAGE, 1'b0, 1'b0, 8'd0, 8'd0, 8'd0, 1'b1, '{7'h20, 7'd0, 8'd0}},
      '{GRAY_AVERAGE, 1'b0, 1'b0, 8'd255, 8'd255, 8'd255, 1'b1, '{7'h40, 7'd9, 8'd255}},
      '{GRAY_AVERAGE, 1'b0, 1'b0, 8'd12, 8'd13, 8'd14, 1'b0, UNTYPED},
      '{GRAY_AVERAGE, 1'b0, 1'b0, 8'd12, 8'd12, 8'd12, 1'b0, UNTYPED},
      '{GRAY_AVERAGE, 1'b1, 1'b0, 8'd255, 8'd255, 8'd255, 1'b1, '{7'h20, 7'd0, 8'd0}},
      '{GRAY_AVERAGE, 1'b0, 1'b1, 8'd255, 8'd255, 8'd255, 1'b1, '{7'h24, 7'd67, 8'd255}},
      '{GRAY_AVERAGE, 1'b0, 1'b1, 8'd0, 8'd0, 8'd0, 1'b1, '{7'h20, 7'd0, 8'd0}},
      '{GRAY_AVERAGE, 1'b1, 1'b1, 8'h55, 8'hAA, 8'h55, 1'b0, UNTYPED},
      '{GRAY_LIGHTNESS, 1'b0, 1'b0, 8'd255, 8'd255, 8'd255, 1'b1, '{7'h40, 7'd9, 8'd255}},
      '{GRAY_LIGHTNESS, 1'b0, 1'b0, 8'd255, 8'd0, 8'd0, 1'b0, UNTYPED},
      '{GRAY_LIGHTNESS, 1'b0, 1'b0, 8'd0, 8'd255, 8'd128, 1'b0, UNTYPED},
      '{GRAY_LIGHTNESS, 1'b0, 1'b1, 8'd1, 8'd254, 8'd128, 1'b0, UNTYPED},
      '{GRAY_LUMINOSITY, 1'b0, 1'b0, 8'd255, 8'd255, 8'd255, 1'b1, '{7'h40, 7'd9, 8'd255}},
      '{GRAY_LUMINOSITY, 1'b0, 1'b0, 8'd255, 8'd0, 8'd0, 1'b0, UNTYPED},
      '{GRAY_LUMINOSITY, 1'b0, 1'b0, 8'd0, 8'd255, 8'd0, 1'b0, UNTYPED},
      '{GRAY_LUMINOSITY, 1'b0, 1'b0, 8'd0, 8'd0, 8'd255, 1'b0, UNTYPED},
      '{GRAY_LUMINOSITY, 1'b1, 1'b1, 8'hAA, 8'h55, 8'hAA, 1'b0, UNTYPED},
      '{GRAY_ZERO, 1'b0, 1'b0, 8'd255, 8'd255, 8'd255, 1'b1, '{7'h20, 7'd0, 8'd0}},
      '{GRAY_ZERO, 1'b1, 1'b0, 8'd0, 8'd0, 8'd0, 1'b1, '{7'h40, 7'd9, 8'd255}},
      '{GRAY_ZERO, 1'b1, 1'b1, 8'd12, 8'd34, 8'd56, 1'b1, '{7'h24, 7'd67, 8'd255}}
   };

   // Brightness ramps, darkest character first.
   string short_ramp = " .:-=+*#%@";
   string long_ramp =
      " .'`^\",:;Il!i~+_-?][}{1)(|\\/tfjrxnuvczXYUJCLQ0OZmwqpdbkhao*#MW&8%B@$";

   logic        clock;
   logic        reset;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [3:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   pxa_pixel_if pixel_bus ();
   pxa_glyph_if glyph_bus ();

   cfg_type          cfg_shadow;
   glyph_result_type expected_glyphs [$];
   glyph_result_type oldest_glyph;
   int               mismatch_count = 0;
   int               quiet_cycles = 0;
   int               send_idle_pct = 0;
   int               rsp_stall_pct = 0;

   pixel_to_ascii_glyph_top uut (
      .clock       (clock),
      .reset       (reset),
      .req_pixel   (pixel_bus),
      .rsp_glyph   (glyph_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Prints one line per wrong field and keeps count.
   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch on %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
      mismatch_count++;
   endtask

   // Computes the glyph for one pixel under the settings currently held in the block.
   function automatic glyph_result_type predict_glyph(input logic [7:0] blue,
                                                      input logic [7:0] green,
                                                      input logic [7:0] red);
      int unsigned b;
      int unsigned g;
      int unsigned r;
      int unsigned brightest;
      int unsigned darkest;
      int unsigned gray;
      int unsigned ramp_len;
      int unsigned idx;
      glyph_result_type res;
      b = 32'(blue);
      g = 32'(green);
      r = 32'(red);
      brightest = (b > g) ? b : g;
      brightest = (brightest > r) ? brightest : r;
      darkest = (b < g) ? b : g;
      darkest = (darkest < r) ? darkest : r;
      case (cfg_shadow.gray_mode)
         GRAY_AVERAGE:    gray = (b + g + r) / 3;
         GRAY_LIGHTNESS:  gray = (brightest + darkest) / 2;
         GRAY_LUMINOSITY: gray = (7 * b + 72 * g + 21 * r) / 100;
         default:         gray = 0;
      endcase
      if (cfg_shadow.invert) begin
         gray = 255 - gray;
      end
      ramp_len = cfg_shadow.ramp_select ? int'(LONG_LEN) : int'(SHORT_LEN);
      // Round half up, then keep a full-scale gray level on the last character.
      idx = (2 * gray * ramp_len + 255) / 510;
      if (idx >= ramp_len) begin
         idx = ramp_len - 1;
      end
      res.glyph = 7'(cfg_shadow.ramp_select ? long_ramp[idx] : short_ramp[idx]);
      res.ramp_index = 7'(idx);
      res.gray_level = 8'(gray);
      return res;
   endfunction

   // Picks one channel value, biased toward the ends of the range.
   function automatic logic [7:0] random_channel();
      case ($urandom_range(7))
         0:       return 8'd0;
         1:       return 8'd255;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   // One APB write: a setup cycle, then an access cycle, then one idle cycle.
   task automatic csr_write(input logic [3:0] addr, input logic [31:0] data);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // One APB read; the data is taken at the edge that ends the access cycle.
   task automatic csr_read(input logic [3:0] addr, output logic [31:0] data);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= addr;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      data = csr_prdata;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // Stops sending and waits until every pixel in flight has produced its glyph.
   task automatic settle_pipeline();
      pixel_bus.valid <= 1'b0;
      while (expected_glyphs.size() != 0) @(posedge clock);
      repeat (PIPE_DRAIN_CYCLES) @(posedge clock);
   endtask

   // Writes all three registers with junk in the unused bits, pokes an unmapped
   // address, and reads the registers back.
   task automatic apply_config(input logic [1:0] mode, input logic inv, input logic ramp);
      logic [31:0] data;
      logic [31:0] readback;
      settle_pipeline();
      data = $urandom();
      data[1:0] = mode;
      csr_write({REG_GRAY_MODE, 2'b00}, data);
      data = $urandom();
      data[0] = inv;
      csr_write({REG_INVERT, 2'b00}, data);
      data = $urandom();
      data[0] = ramp;
      csr_write({REG_RAMP_SELECT, 2'b00}, data);
      csr_write(UNMAPPED_ADDR, $urandom());
      cfg_shadow.gray_mode = mode;
      cfg_shadow.invert = inv;
      cfg_shadow.ramp_select = ramp;
      csr_read({REG_GRAY_MODE, 2'b00}, readback);
      if (readback[1:0] !== mode) begin
         report_mismatch("gray_mode readback", int'(readback[1:0]), int'(mode));
      end
      csr_read({REG_INVERT, 2'b00}, readback);
      if (readback[0] !== inv) begin
         report_mismatch("invert readback", int'(readback[0]), int'(inv));
      end
      csr_read({REG_RAMP_SELECT, 2'b00}, readback);
      if (readback[0] !== ramp) begin
         report_mismatch("ramp_select readback", int'(readback[0]), int'(ramp));
      end
   endtask

   // Offers one pixel after a random gap and records its glyph once it is taken.
   task automatic send_pixel(input logic [7:0] blue, input logic [7:0] green,
                             input logic [7:0] red, input logic typed,
                             input glyph_result_type want);
      while ($urandom_range(99) < send_idle_pct) begin
         pixel_bus.valid <= 1'b0;
         pixel_bus.blue <= 8'($urandom());
         pixel_bus.green <= 8'($urandom());
         pixel_bus.red <= 8'($urandom());
         @(posedge clock);
      end
      pixel_bus.valid <= 1'b1;
      pixel_bus.blue <= blue;
      pixel_bus.green <= green;
      pixel_bus.red <= red;
      do @(posedge clock); while (!pixel_bus.ready);
      expected_glyphs.push_back(typed ? want : predict_glyph(blue, green, red));
   endtask

   // The receiver stalls at random according to the current phase.
   always @(posedge clock) begin
      glyph_bus.ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // Checks every glyph transaction against the oldest expectation and watches for hangs.
   always @(posedge clock) begin
      if (!reset && glyph_bus.valid && glyph_bus.ready) begin
         if (expected_glyphs.size() == 0) begin
            report_mismatch("unexpected glyph", int'(glyph_bus.glyph), -1);
         end else begin
            oldest_glyph = expected_glyphs.pop_front();
            if (glyph_bus.glyph !== oldest_glyph.glyph) begin
               report_mismatch("glyph", int'(glyph_bus.glyph), int'(oldest_glyph.glyph));
            end
            if (glyph_bus.ramp_index !== oldest_glyph.ramp_index) begin
               report_mismatch("ramp_index", int'(glyph_bus.ramp_index),
                               int'(oldest_glyph.ramp_index));
            end
            if (glyph_bus.gray_level !== oldest_glyph.gray_level) begin
               report_mismatch("gray_level", int'(glyph_bus.gray_level),
                               int'(oldest_glyph.gray_level));
            end
         end
      end
      if ((pixel_bus.valid && pixel_bus.ready) || (glyph_bus.valid && glyph_bus.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
         $display("Mismatches found");
         $finish;
      end
   end

   // Stimulus: directed table first, then random segments across all settings.
   initial begin
      pixel_case_type row;
      logic [4:0]     seg;
      reset <= 1'b1;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= '0;
      csr_pwdata <= '0;
      pixel_bus.valid <= 1'b0;
      pixel_bus.blue <= '0;
      pixel_bus.green <= '0;
      pixel_bus.red <= '0;
      cfg_shadow = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed rows run with neither side idling.
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      apply_config(GRAY_AVERAGE, 1'b0, 1'b0);
      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         row = directed_cases[i];
         if (row.gray_mode !== cfg_shadow.gray_mode || row.invert !== cfg_shadow.invert ||
             row.ramp_select !== cfg_shadow.ramp_select) begin
            apply_config(row.gray_mode, row.invert, row.ramp_select);
         end
         send_pixel(row.blue, row.green, row.red, row.typed, row.want);
      end

      // Every combination of settings comes up twice, each time in another idle phase.
      for (int s = 0; s < SEGMENTS; s++) begin
         seg = 5'(s);
         apply_config(seg[1:0], seg[2], seg[3]);
         case (seg[3:2] ^ {2{seg[4]}})
            2'd0: begin
               send_idle_pct = 0;
               rsp_stall_pct = 0;
            end
            2'd1: begin
               send_idle_pct = 68;
               rsp_stall_pct = 0;
            end
            2'd2: begin
               send_idle_pct = 0;
               rsp_stall_pct = 68;
            end
            default: begin
               send_idle_pct = 33;
               rsp_stall_pct = 33;
            end
         endcase
         for (int j = 0; j < PIXELS_PER_SEGMENT; j++) begin
            // Now and then the sender holds off until the pipeline is empty.
            if (seg[2:0] == 3'd4 && j == PIXELS_PER_SEGMENT / 2) begin
               settle_pipeline();
            end
            if ($urandom_range(7) == 0) begin
               row.blue = random_channel();
               send_pixel(row.blue, row.blue, row.blue, 1'b0, UNTYPED);
            end else begin
               send_pixel(random_channel(), random_channel(), random_channel(),
                          1'b0, UNTYPED);
            end
         end
      end

      settle_pipeline();
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

FILE: files.f
rtl/pxa_pkg.sv
rtl/pxa_if.sv
rtl/pxa_csr.sv
rtl/pxa_gray.sv
rtl/pxa_quant.sv
rtl/pxa_glyph.sv
rtl/pixel_to_ascii_glyph_top.sv
tb/sv/pixel_to_ascii_glyph_top_tb.sv
